// ===== src/nearest_timestamp_frame_sync_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame synchronizer
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TIMESTAMP_FRAME_SYNC_CORE_DEFINES_SVH
`define NEAREST_TIMESTAMP_FRAME_SYNC_CORE_DEFINES_SVH

// Same-cycle implication.
`define NTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg
// Types and constants shared by the frame synchronizer modules.
// ----------------------------------------------------------------------------
package nts_pkg;

   localparam int STAMP_W = 63;
   localparam int TAG_W   = 16;
   localparam int TOL_W   = 32;

   localparam int HISTORY_DEPTH_DEF = 30;
   localparam int TAG_BITS_DEF      = 16;

   localparam logic [TOL_W-1:0] TOL_RESET = 32'd10000000;

   localparam logic STREAM_COLOR = 1'b0;
   localparam logic STREAM_DEPTH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_RESULT
   } state_type;

   // Control that rides along with one history entry through the search pipe.
   typedef struct packed {
      logic valid;
      logic stream;
      logic last;
   } beat_type;

   // Status of the shared distance unit.
   typedef struct packed {
      logic done;
      logic have_c;
      logic have_d;
   } near_status_type;

endpackage

// ===== src/nts_req_if.sv =====
// ----------------------------------------------------------------------------
// nts_req_if
// Frame arrival channel: stream select, capture stamp and buffer tag.
// ----------------------------------------------------------------------------
interface nts_req_if;
   import nts_pkg::*;

   logic               valid;
   logic               ready;
   logic               func;
   logic [STAMP_W-1:0] stamp;
   logic [TAG_W-1:0]   frame_tag;

   modport source (output valid, output func, output stamp, output frame_tag,
                   input ready);
   modport sink   (input valid, input func, input stamp, input frame_tag,
                   output ready);
endinterface

// ===== src/nts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nts_rsp_if
// Pair result channel: match flag, chosen tags and stamps.
// ----------------------------------------------------------------------------
interface nts_rsp_if;
   import nts_pkg::*;

   logic               valid;
   logic               ready;
   logic               pair_found;
   logic [TAG_W-1:0]   color_tag;
   logic [TAG_W-1:0]   depth_tag;
   logic [STAMP_W-1:0] color_stamp;
   logic [STAMP_W-1:0] depth_stamp;

   modport source (output valid, output pair_found, output color_tag,
                   output depth_tag, output color_stamp, output depth_stamp,
                   input ready);
   modport sink   (input valid, input pair_found, input color_tag,
                   input depth_tag, input color_stamp, input depth_stamp,
                   output ready);
endinterface

// ===== src/nts_csr_if.sv =====
// ----------------------------------------------------------------------------
// nts_csr_if
// Configuration write channel for the match tolerance register.
// ----------------------------------------------------------------------------
interface nts_csr_if;
   import nts_pkg::*;

   logic             valid;
   logic             ready;
   logic [TOL_W-1:0] sync_tolerance;

   modport source (output valid, output sync_tolerance, input ready);
   modport sink   (input valid, input sync_tolerance, output ready);
endinterface

// ===== src/nts_hist.sv =====
// ----------------------------------------------------------------------------
// nts_hist
// Color and depth frame histories in one memory, ring pointers and the
// address sequencer that walks both histories oldest first.
// ----------------------------------------------------------------------------
module nts_hist #(
   parameter int HISTORY_DEPTH = nts_pkg::HISTORY_DEPTH_DEF,
   parameter int TAG_BITS      = nts_pkg::TAG_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  logic                      push_stream,
   input  logic [nts_pkg::STAMP_W-1:0] push_stamp,
   input  logic [TAG_BITS-1:0]       push_tag,
   input  logic                      scan_start,
   output logic                      both_held,
   output nts_pkg::beat_type         rd_beat,
   output logic [nts_pkg::STAMP_W-1:0] rd_stamp,
   output logic [TAG_BITS-1:0]       rd_tag
);
   import nts_pkg::*;

   localparam int SLOT_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W     = SLOT_W + 2;
   localparam int ADDR_W    = SLOT_W + 1;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam int ENTRY_W   = STAMP_W + TAG_BITS;

   localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
   localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(HISTORY_DEPTH);

   logic [ENTRY_W-1:0] mem [MEM_DEPTH];

   logic [CNT_W-1:0]  cnt_c_ff, cnt_c_in, cnt_d_ff, cnt_d_in;
   logic [SLOT_W-1:0] old_c_ff, old_c_in, old_d_ff, old_d_in;

   logic [CNT_W-1:0]  cnt_sel;
   logic [SLOT_W-1:0] old_sel, old_next, wr_slot;
   logic [SUM_W-1:0]  sum, sum_wrap;
   logic              full;

   logic              act_ff, act_in;
   logic              strm_ff, strm_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  cnt_cur;
   logic              idx_last;

   beat_type           beat_ff;
   logic [ENTRY_W-1:0] entry_ff;

   // Write slot: append after the newest entry, or overwrite the oldest.
   always_comb begin
      cnt_sel  = push_stream ? cnt_d_ff : cnt_c_ff;
      old_sel  = push_stream ? old_d_ff : old_c_ff;
      full     = (cnt_sel == DEPTH_CNT);
      old_next = (old_sel == LAST_SLOT) ? '0 : old_sel + SLOT_W'(1);
      sum      = SUM_W'(old_sel) + SUM_W'(cnt_sel);
      sum_wrap = (sum >= DEPTH_SUM) ? sum - DEPTH_SUM : sum;
      wr_slot  = full ? old_sel : sum_wrap[SLOT_W-1:0];

      cnt_c_in = cnt_c_ff;
      cnt_d_in = cnt_d_ff;
      old_c_in = old_c_ff;
      old_d_in = old_d_ff;
      if (push_valid) begin
         if (push_stream == STREAM_DEPTH) begin
            if (full) old_d_in = old_next;
            else      cnt_d_in = cnt_d_ff + CNT_W'(1);
         end else begin
            if (full) old_c_in = old_next;
            else      cnt_c_in = cnt_c_ff + CNT_W'(1);
         end
      end
   end

   // Walk color history, then depth history, one entry a cycle.
   always_comb begin
      cnt_cur  = strm_ff ? cnt_d_ff : cnt_c_ff;
      idx_last = (idx_ff == cnt_cur - CNT_W'(1));
      act_in   = act_ff;
      strm_in  = strm_ff;
      idx_in   = idx_ff;
      slot_in  = slot_ff;
      if (scan_start) begin
         act_in  = 1'b1;
         strm_in = STREAM_COLOR;
         idx_in  = '0;
         slot_in = old_c_ff;
      end else if (act_ff) begin
         if (idx_last) begin
            if (strm_ff == STREAM_COLOR) begin
               strm_in = STREAM_DEPTH;
               idx_in  = '0;
               slot_in = old_d_ff;
            end else begin
               act_in = 1'b0;
            end
         end else begin
            idx_in  = idx_ff + CNT_W'(1);
            slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_c_ff <= '0;
         cnt_d_ff <= '0;
         old_c_ff <= '0;
         old_d_ff <= '0;
         act_ff   <= 1'b0;
         beat_ff  <= '0;
      end else begin
         cnt_c_ff <= cnt_c_in;
         cnt_d_ff <= cnt_d_in;
         old_c_ff <= old_c_in;
         old_d_ff <= old_d_in;
         act_ff   <= act_in;
         beat_ff  <= '{valid: act_ff, stream: strm_ff,
                       last: act_ff && strm_ff && idx_last};
      end
   end

   always_ff @(posedge clock) begin
      strm_ff <= strm_in;
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem[{push_stream, wr_slot}] <= {push_stamp, push_tag};
      end
   end

   always_ff @(posedge clock) begin
      if (act_ff) begin
         entry_ff <= mem[{strm_ff, slot_ff}];
      end
   end

   assign both_held = (cnt_c_ff != '0) && (cnt_d_ff != '0);
   assign rd_beat   = beat_ff;
   assign rd_stamp  = entry_ff[ENTRY_W-1:TAG_BITS];
   assign rd_tag    = entry_ff[TAG_BITS-1:0];

endmodule

// ===== src/nts_near.sv =====
// ----------------------------------------------------------------------------
// nts_near
// Shared distance unit: absolute stamp difference, then compare against the
// running best of the entry's stream. Strict less-than keeps older on ties.
// ----------------------------------------------------------------------------
module nts_near #(
   parameter int TAG_BITS = nts_pkg::TAG_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  nts_pkg::beat_type           in_beat,
   input  logic [nts_pkg::STAMP_W-1:0] in_stamp,
   input  logic [TAG_BITS-1:0]         in_tag,
   input  logic [nts_pkg::STAMP_W-1:0] target,
   output nts_pkg::near_status_type    status,
   output logic [nts_pkg::STAMP_W-1:0] best_c_stamp,
   output logic [TAG_BITS-1:0]         best_c_tag,
   output logic [nts_pkg::STAMP_W-1:0] best_c_dist,
   output logic [nts_pkg::STAMP_W-1:0] best_d_stamp,
   output logic [TAG_BITS-1:0]         best_d_tag,
   output logic [nts_pkg::STAMP_W-1:0] best_d_dist
);
   import nts_pkg::*;

   logic [STAMP_W:0]   diff_a, diff_b;
   logic [STAMP_W-1:0] gap;

   beat_type           beat_ff;
   logic [STAMP_W-1:0] dist_ff, stamp_ff;
   logic [TAG_BITS-1:0] tag_ff;

   logic               have_c_ff, have_d_ff, done_ff;
   logic [STAMP_W-1:0] c_stamp_ff, c_dist_ff, d_stamp_ff, d_dist_ff;
   logic [TAG_BITS-1:0] c_tag_ff, d_tag_ff;

   logic               have_sel, take;
   logic [STAMP_W-1:0] best_sel;

   // Both differences in parallel; the borrow picks the non-negative one.
   always_comb begin
      diff_a = {1'b0, in_stamp} - {1'b0, target};
      diff_b = {1'b0, target} - {1'b0, in_stamp};
      gap    = diff_a[STAMP_W] ? diff_b[STAMP_W-1:0] : diff_a[STAMP_W-1:0];
   end

   always_comb begin
      have_sel = beat_ff.stream ? have_d_ff : have_c_ff;
      best_sel = beat_ff.stream ? d_dist_ff : c_dist_ff;
      take     = beat_ff.valid && (!have_sel || (dist_ff < best_sel));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff   <= '0;
         have_c_ff <= 1'b0;
         have_d_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         beat_ff <= in_beat;
         done_ff <= beat_ff.valid && beat_ff.last;
         if (clear) begin
            have_c_ff <= 1'b0;
            have_d_ff <= 1'b0;
         end else if (take) begin
            if (beat_ff.stream == STREAM_DEPTH) have_d_ff <= 1'b1;
            else                                have_c_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dist_ff  <= gap;
      stamp_ff <= in_stamp;
      tag_ff   <= in_tag;
      if (take) begin
         if (beat_ff.stream == STREAM_DEPTH) begin
            d_dist_ff  <= dist_ff;
            d_stamp_ff <= stamp_ff;
            d_tag_ff   <= tag_ff;
         end else begin
            c_dist_ff  <= dist_ff;
            c_stamp_ff <= stamp_ff;
            c_tag_ff   <= tag_ff;
         end
      end
   end

   assign status       = '{done: done_ff, have_c: have_c_ff, have_d: have_d_ff};
   assign best_c_stamp = c_stamp_ff;
   assign best_c_tag   = c_tag_ff;
   assign best_c_dist  = c_dist_ff;
   assign best_d_stamp = d_stamp_ff;
   assign best_d_tag   = d_tag_ff;
   assign best_d_dist  = d_dist_ff;

endmodule

// ===== src/nearest_timestamp_frame_sync_core.sv =====
// ----------------------------------------------------------------------------
// nearest_timestamp_frame_sync_core
// Pairs color and depth frames whose capture stamps lie nearest each other.
// ----------------------------------------------------------------------------
// Each request transaction announces one frame on the color stream (func 0)
// or the depth stream (func 1). The frame's stamp and tag are appended to
// that stream's ring history of HISTORY_DEPTH entries, overwriting the
// oldest once the ring is full. Both histories are then searched for the
// entry nearest the arriving stamp, older entry winning a tie, and exactly
// one response transaction follows. It carries a pair when both histories
// hold frames, both best distances are within sync_tolerance and the color
// stamp differs from the last released one; otherwise pair_found is 0 and
// every other field is 0. The search walks every held entry through one
// shared distance and compare unit, one entry a cycle, and is skipped while
// a history is still empty. req_ch.ready is low from acceptance until the
// core is ready again. The response sits in an output register; a stalled
// response holds the core only at the point where the next result is due.
// The tolerance register resets to 10000000 ns and is written through
// csr_ch, which is always ready; write it only while no request is pending.
// ----------------------------------------------------------------------------
`include "nearest_timestamp_frame_sync_core_defines.svh"

module nearest_timestamp_frame_sync_core #(
   parameter int HISTORY_DEPTH = nts_pkg::HISTORY_DEPTH_DEF,
   parameter int TAG_BITS      = nts_pkg::TAG_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   nts_req_if.sink   req_ch,
   nts_rsp_if.source rsp_ch,
   nts_csr_if.sink   csr_ch
);
   import nts_pkg::*;

   // Sequencer state
   state_type state_ff, state_in;

   logic               req_accept;
   logic               scan_start;
   logic               load_out;
   logic               out_free;
   logic               found;

   logic [TAG_BITS+TAG_W-1:0] tag_in_ext;
   logic [TAG_BITS+TAG_W-1:0] ctag_ext, dtag_ext;

   // History and distance unit connections
   logic               both_held;
   beat_type           rd_beat;
   logic [STAMP_W-1:0] rd_stamp;
   logic [TAG_BITS-1:0] rd_tag;
   near_status_type    near_st;
   logic [STAMP_W-1:0] best_c_stamp, best_c_dist, best_d_stamp, best_d_dist;
   logic [TAG_BITS-1:0] best_c_tag, best_d_tag;

   // Held request stamp, tolerance and last released color stamp
   logic [STAMP_W-1:0] target_ff;
   logic [TOL_W-1:0]   tol_ff;
   logic [STAMP_W-1:0] last_ff;

   // Output register
   logic               rsp_valid_ff;
   logic               found_ff;
   logic [TAG_W-1:0]   ctag_ff, dtag_ff;
   logic [STAMP_W-1:0] cstamp_ff, dstamp_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   // Keep only the low TAG_BITS bits of the incoming buffer tag.
   assign tag_in_ext = {{TAG_BITS{1'b0}}, req_ch.frame_tag};

   nts_hist #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .TAG_BITS      (TAG_BITS)
   ) u_hist (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (req_accept),
      .push_stream (req_ch.func),
      .push_stamp  (req_ch.stamp),
      .push_tag    (tag_in_ext[TAG_BITS-1:0]),
      .scan_start  (scan_start),
      .both_held   (both_held),
      .rd_beat     (rd_beat),
      .rd_stamp    (rd_stamp),
      .rd_tag      (rd_tag)
   );

   nts_near #(
      .TAG_BITS (TAG_BITS)
   ) u_near (
      .clock        (clock),
      .reset        (reset),
      .clear        (scan_start),
      .in_beat      (rd_beat),
      .in_stamp     (rd_stamp),
      .in_tag       (rd_tag),
      .target       (target_ff),
      .status       (near_st),
      .best_c_stamp (best_c_stamp),
      .best_c_tag   (best_c_tag),
      .best_c_dist  (best_c_dist),
      .best_d_stamp (best_d_stamp),
      .best_d_tag   (best_d_tag),
      .best_d_dist  (best_d_dist)
   );

   // Release a pair only when both histories hold frames, both matches are
   // within tolerance and the color stamp differs from the last released one.
   always_comb begin
      found = both_held && near_st.have_c && near_st.have_d &&
              (best_c_dist <= STAMP_W'(tol_ff)) &&
              (best_d_dist <= STAMP_W'(tol_ff)) &&
              (best_c_stamp != last_ff);
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Next state: accept, start the walk (or skip it while a history is
   // empty), wait for the last entry to clear the compare, then hand the
   // result to the output register once it is free.
   always_comb begin
      state_in   = state_ff;
      scan_start = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_START;
         end
         ST_START: begin
            if (both_held) begin
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_SCAN: begin
            if (near_st.done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) tol_ff <= csr_ch.sync_tolerance;
         if (load_out && found) last_ff <= best_c_stamp;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign ctag_ext = {{TAG_W{1'b0}}, best_c_tag};
   assign dtag_ext = {{TAG_W{1'b0}}, best_d_tag};

   // Payload: hold the arriving stamp, zero the fields when no pair.
   always_ff @(posedge clock) begin
      if (req_accept) target_ff <= req_ch.stamp;
      if (load_out) begin
         found_ff  <= found;
         ctag_ff   <= found ? ctag_ext[TAG_W-1:0] : '0;
         dtag_ff   <= found ? dtag_ext[TAG_W-1:0] : '0;
         cstamp_ff <= found ? best_c_stamp : '0;
         dstamp_ff <= found ? best_d_stamp : '0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pair_found  = found_ff;
   assign rsp_ch.color_tag   = ctag_ff;
   assign rsp_ch.depth_tag   = dtag_ff;
   assign rsp_ch.color_stamp = cstamp_ff;
   assign rsp_ch.depth_stamp = dstamp_ff;

   // Assertions
   `NTS_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept, state_ff == ST_START, "accepted request did not start search")
   `NTS_ASSERT_NOW(a_done_in_scan, clock, reset, near_st.done, state_ff == ST_SCAN, "search finished outside scan")
   `NTS_ASSERT_NOW(a_nopair_zero, clock, reset, rsp_ch.valid && !rsp_ch.pair_found, (rsp_ch.color_stamp == '0) && (rsp_ch.depth_stamp == '0) && (rsp_ch.color_tag == '0) && (rsp_ch.depth_tag == '0), "non-pair response carries data")
   `NTS_ASSERT_NOW(a_pair_is_last, clock, reset, rsp_ch.valid && rsp_ch.pair_found, rsp_ch.color_stamp == last_ff, "released color stamp not recorded")

endmodule

// ===== bench/nearest_timestamp_frame_sync_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_timestamp_frame_sync_core_tb
// Drives color and depth frame arrivals into the synchronizer and checks each
// pair result against a local model of the two ring histories, the nearest
// stamp search and the release rule, under random stalls on both channels.
// ----------------------------------------------------------------------------
module nearest_timestamp_frame_sync_core_tb;
   import nts_pkg::*;

   localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
   localparam int IDLE_GAP       = 80;     // covers the longest search at the default depth
   localparam int WATCHDOG_LIMIT = 2000;   // cycles without any transaction
   localparam int FRAME_PERIOD   = 33_000_000;

   typedef struct packed {
      logic               pair_found;
      logic [TAG_W-1:0]   color_tag;
      logic [TAG_W-1:0]   depth_tag;
      logic [STAMP_W-1:0] color_stamp;
      logic [STAMP_W-1:0] depth_stamp;
   } pair_type;

   logic clock;
   logic reset;

   nts_req_if req_ch ();
   nts_rsp_if rsp_ch ();
   nts_csr_if csr_ch ();

   nearest_timestamp_frame_sync_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Local copy of the block's state, indexed by stream (color 0, depth 1).
   logic [STAMP_W-1:0] hist_stamp [2][HISTORY_DEPTH_DEF];
   logic [TAG_W-1:0]   hist_tag   [2][HISTORY_DEPTH_DEF];
   int                 hist_count [2] = '{0, 0};
   int                 hist_oldest[2] = '{0, 0};
   logic [STAMP_W-1:0] last_released = '0;
   logic [TOL_W-1:0]   tolerance = TOL_RESET;

   pair_type pending_pairs[$];
   int    failures = 0;
   bit    steady = 1'b0;        // no idling on either side while set
   bit    hold_request = 1'b0;  // asks the receiver for one long hold-off

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Search one history, oldest first, for the stamp nearest the target.
   // A strict less-than keeps the older entry on a tie. Returns whether the
   // best distance is within the tolerance.
   function automatic bit find_nearest(input logic stream,
                                       input logic [STAMP_W-1:0] target,
                                       output logic [STAMP_W-1:0] best_stamp,
                                       output logic [TAG_W-1:0] best_tag);
      logic [STAMP_W-1:0] distance;
      logic [STAMP_W-1:0] best_dist;
      int slot;
      best_dist  = '0;
      best_stamp = '0;
      best_tag   = '0;
      for (int i = 0; i < hist_count[stream]; i++) begin
         slot = (hist_oldest[stream] + i) % HISTORY_DEPTH_DEF;
         distance = (hist_stamp[stream][slot] > target) ? hist_stamp[stream][slot] - target
                                                        : target - hist_stamp[stream][slot];
         if (i == 0 || distance < best_dist) begin
            best_dist  = distance;
            best_stamp = hist_stamp[stream][slot];
            best_tag   = hist_tag[stream][slot];
         end
      end
      return hist_count[stream] > 0 && best_dist <= {31'b0, tolerance};
   endfunction

   // Append the arriving frame, search both histories and decide the release.
   function automatic pair_type predict_pair(input logic stream,
                                             input logic [STAMP_W-1:0] stamp,
                                             input logic [TAG_W-1:0] tag);
      pair_type           pair;
      int                 slot;
      logic [STAMP_W-1:0] cs, ds;
      logic [TAG_W-1:0]   ct, dt;
      bit                 color_ok, depth_ok;
      pair = '0;
      if (hist_count[stream] < HISTORY_DEPTH_DEF) begin
         slot = (hist_oldest[stream] + hist_count[stream]) % HISTORY_DEPTH_DEF;
         hist_count[stream]++;
      end else begin
         // full ring: overwrite the oldest entry and advance past it
         slot = hist_oldest[stream];
         hist_oldest[stream] = (slot + 1) % HISTORY_DEPTH_DEF;
      end
      hist_stamp[stream][slot] = stamp;
      hist_tag[stream][slot]   = tag;
      if (hist_count[STREAM_COLOR] > 0 && hist_count[STREAM_DEPTH] > 0) begin
         color_ok = find_nearest(STREAM_COLOR, stamp, cs, ct);
         depth_ok = find_nearest(STREAM_DEPTH, stamp, ds, dt);
         if (color_ok && depth_ok && cs != last_released) begin
            last_released    = cs;
            pair.pair_found  = 1'b1;
            pair.color_tag   = ct;
            pair.depth_tag   = dt;
            pair.color_stamp = cs;
            pair.depth_stamp = ds;
         end
      end
      return pair;
   endfunction

   function automatic logic [STAMP_W-1:0] random_stamp();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[STAMP_W-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one frame and record its expected pair once accepted. Valid is
   // left high after acceptance so that a back-to-back frame never lowers
   // and raises it in one time step; idle cycles and drain_pairs drop it.
   task automatic send_frame(input logic stream, input logic [STAMP_W-1:0] stamp,
                             input logic [TAG_W-1:0] tag);
      while (!steady && $urandom_range(99) < 8) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= stream;
      req_ch.stamp     <= stamp;
      req_ch.frame_tag <= tag;
      do @(posedge clock); while (!req_ch.ready);
      pending_pairs.insert(pending_pairs.size(), predict_pair(stream, stamp, tag));
   endtask

   // Drop valid, wait for every expected pair, then let the core settle.
   task automatic drain_pairs();
      req_ch.valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_W-1:0] value);
      drain_pairs();
      csr_ch.valid          <= 1'b1;
      csr_ch.sync_tolerance <= value;
      do @(posedge clock); while (!csr_ch.ready);
      tolerance = value;
      csr_ch.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // Random back-pressure; a hold request turns into one long hold-off,
   // counted here, during which the sender keeps offering frames.
   initial begin : rsp_ready_driver
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 8);
         end
      end
   end

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   // Compare each accepted result against the oldest expected pair.
   always @(posedge clock) begin
      pair_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pairs.size() == 0) begin
            $error("pair result with no frame waiting for it");
            failures++;
         end else begin
            want = pending_pairs[0];
            pending_pairs.delete(0);
            check_field("pair_found", 64'(want.pair_found), 64'(rsp_ch.pair_found));
            check_field("color_tag", 64'(want.color_tag), 64'(rsp_ch.color_tag));
            check_field("depth_tag", 64'(want.depth_tag), 64'(rsp_ch.depth_tag));
            check_field("color_stamp", 64'(want.color_stamp), 64'(rsp_ch.color_stamp));
            check_field("depth_stamp", 64'(want.depth_stamp), 64'(rsp_ch.depth_stamp));
         end
      end
   end

   // Abort when no transaction moves on any channel for too long.
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Stamp zero on both streams right after reset matches the reset value of
   // the last released stamp, so no pair; a fresh color stamp then releases,
   // and choosing that same color frame again releases nothing.
   task automatic test_zero_stamp_startup();
      send_frame(STREAM_COLOR, 63'd0, 16'h0000);
      send_frame(STREAM_DEPTH, 63'd0, 16'hFFFF);
      send_frame(STREAM_COLOR, 63'd5, 16'h0001);
      send_frame(STREAM_DEPTH, 63'd5, 16'h0002);
   endtask

   // Equal distance on either stream: the older entry must win. Includes two
   // color frames with the same stamp and different tags.
   task automatic test_nearest_tie_break();
      send_frame(STREAM_COLOR, 63'd100, 16'h0100);
      send_frame(STREAM_COLOR, 63'd120, 16'h0120);
      send_frame(STREAM_DEPTH, 63'd110, 16'h0110);   // color tie 100 / 120
      send_frame(STREAM_DEPTH, 63'd130, 16'h0130);
      send_frame(STREAM_COLOR, 63'd220, 16'h0220);
      send_frame(STREAM_COLOR, 63'd120, 16'hA120);   // depth tie 110 / 130
      send_frame(STREAM_DEPTH, 63'd121, 16'h0121);   // same color chosen again
   endtask

   task automatic test_stamp_extremes();
      send_frame(STREAM_COLOR, {STAMP_W{1'b1}}, 16'hFFFF);
      send_frame(STREAM_DEPTH, {STAMP_W{1'b1}}, 16'h0000);
   endtask

   // Zero tolerance: only an exact stamp match pairs.
   task automatic test_tolerance_zero();
      logic [STAMP_W-1:0] base;
      base = 63'h0000_1000_0000_0000;
      write_tolerance('0);
      send_frame(STREAM_COLOR, base, 16'h5A5A);
      send_frame(STREAM_DEPTH, base, 16'hA5A5);
      send_frame(STREAM_DEPTH, base + 1, 16'h00FF);
      send_frame(STREAM_COLOR, base + 2, 16'hFF00);
   endtask

   // Full tolerance: a distance of 2^32 - 1 still pairs, 2^33 does not.
   task automatic test_tolerance_max();
      logic [STAMP_W-1:0] base;
      base = 63'h0000_2000_0000_0000;
      write_tolerance('1);
      send_frame(STREAM_COLOR, base, 16'h1234);
      send_frame(STREAM_DEPTH, base + 63'h0_FFFF_FFFF, 16'h4321);
      send_frame(STREAM_DEPTH, base + 63'h2_0000_0000, 16'h8001);
   endtask

   // Two interleaved camera streams at about 30 Hz with random phase offset,
   // jitter and dropped frames, mixed with repeated stamps and noise frames
   // anywhere in the stamp range. Histories wrap many times over.
   task automatic run_frame_stream(input int items, input int hold_at,
                                   input int steady_from, input int steady_to);
      logic [STAMP_W-1:0] next_stamp [2];
      logic [STAMP_W-1:0] last_stamp;
      logic               stream;
      int                 roll;
      next_stamp[STREAM_COLOR] = random_stamp() >> 2;
      next_stamp[STREAM_DEPTH] = next_stamp[STREAM_COLOR] + $urandom_range(20_000_000);
      last_stamp = next_stamp[STREAM_COLOR];
      for (int i = 0; i < items; i++) begin
         steady = (i >= steady_from && i < steady_to);
         if (i == hold_at) hold_request = 1'b1;
         roll = $urandom_range(99);
         if (roll < 8) begin
            send_frame(1'($urandom_range(1)), random_stamp(),
                       TAG_W'($urandom_range(16'hFFFF)));
         end else if (roll < 14) begin
            send_frame(1'($urandom_range(1)), last_stamp,
                       TAG_W'($urandom_range(16'hFFFF)));
         end else begin
            // advance whichever stream is due next
            stream = next_stamp[STREAM_DEPTH] < next_stamp[STREAM_COLOR];
            if (roll < 18) next_stamp[stream] += FRAME_PERIOD;   // dropped frame
            last_stamp = next_stamp[stream];
            send_frame(stream, last_stamp, TAG_W'($urandom_range(16'hFFFF)));
            next_stamp[stream] += $urandom_range(FRAME_PERIOD + 2_000_000,
                                                 FRAME_PERIOD - 2_000_000);
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_frame_streams();
      write_tolerance(TOL_RESET);
      run_frame_stream(200, 40, 100, 160);
      write_tolerance($urandom_range(50_000_000, 1_000));
      run_frame_stream(150, -1, -1, -1);
      write_tolerance('1);
      run_frame_stream(150, 70, 20, 60);
   endtask

   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.func           <= STREAM_COLOR;
      req_ch.stamp          <= '0;
      req_ch.frame_tag      <= '0;
      csr_ch.valid          <= 1'b0;
      csr_ch.sync_tolerance <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_zero_stamp_startup();
      test_nearest_tie_break();
      test_stamp_extremes();
      test_tolerance_zero();
      test_tolerance_max();
      test_frame_streams();

      drain_pairs();
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
